// File: rtl/core/ureg_pkg.sv
// Package for the serial port register block: command codes, register
// indexes, control/status bit positions and field widths.
// No dependencies.
package ureg_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CharW  = 9;
  localparam int unsigned CtrlW  = 20;
  localparam int unsigned ModeW  = 29;
  localparam int unsigned StatW  = 14;
  localparam int unsigned RtoW   = 16;
  localparam int unsigned BrW    = 11;
  localparam int unsigned IrdaW  = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RX_CHAR = 2'd2,
    CMD_TX_SLOT = 2'd3
  } cmd_e;

  typedef enum logic [IdxW-1:0] {
    REG_CR   = 5'd0,
    REG_MR   = 5'd1,
    REG_IER  = 5'd2,
    REG_IDR  = 5'd3,
    REG_IMR  = 5'd4,
    REG_CSR  = 5'd5,
    REG_RHR  = 5'd6,
    REG_THR  = 5'd7,
    REG_BRGR = 5'd8,
    REG_RTOR = 5'd9,
    REG_TTGR = 5'd10,
    REG_FIDI = 5'd16,
    REG_NER  = 5'd17,
    REG_IF   = 5'd19
  } reg_e;

  // Control word bits
  localparam logic [CtrlW-1:0] CrRxEn   = 20'h00010;
  localparam logic [CtrlW-1:0] CrRxDis  = 20'h00020;
  localparam logic [CtrlW-1:0] CrTxEn   = 20'h00040;
  localparam logic [CtrlW-1:0] CrTxDis  = 20'h00080;
  localparam logic [CtrlW-1:0] CrEna    = 20'h54050;
  localparam logic [CtrlW-1:0] CrDisa   = 20'hA80A0;
  localparam logic [CtrlW-1:0] CrAction = 20'h0F90C;

  // Status bit positions
  localparam int unsigned StRxRdy   = 0;
  localparam int unsigned StTxRdy   = 1;
  localparam int unsigned StTxEmpty = 9;
  localparam logic [StatW-1:0] StReset = 14'h0202;

  localparam logic [CtrlW-1:0] ImBits  = 20'hF3FFF;
  localparam logic [ModeW-1:0] MrBits  = 29'h173FFFFF;
  localparam logic [BrW-1:0]   BrReset = 11'h174;

endpackage

// File: rtl/core/ureg_req_if.sv
// Request channel of the serial port register block: valid/ready and the
// item fields. Depends on ureg_pkg for field widths.
interface ureg_req_if;
  logic                           valid;
  logic                           ready;
  logic [ureg_pkg::CmdW-1:0]      command;
  logic [ureg_pkg::IdxW-1:0]      reg_index;
  logic [ureg_pkg::DataW-1:0]     write_data;
  logic [ureg_pkg::CharW-1:0]     rx_char;

  modport source (output valid, command, reg_index, write_data, rx_char, input ready);
  modport sink   (input valid, command, reg_index, write_data, rx_char, output ready);
endinterface

// File: rtl/core/ureg_rsp_if.sv
// Response channel of the serial port register block: valid/ready and the
// result fields. Depends on ureg_pkg for field widths.
interface ureg_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ureg_pkg::DataW-1:0]     read_data;
  logic                           irq;
  logic                           tx_valid;
  logic [ureg_pkg::CharW-1:0]     tx_char;
  logic                           rx_listening;
  logic                           tx_busy;

  modport source (output valid, read_data, irq, tx_valid, tx_char, rx_listening, tx_busy,
                  input ready);
  modport sink   (input valid, read_data, irq, tx_valid, tx_char, rx_listening, tx_busy,
                  output ready);
endinterface

// File: rtl/core/usart_register_block_top.sv
// Top level of the serial port register block: register file, status flags,
// receive holding and double-buffered transmitter. Uses ureg_pkg,
// ureg_req_if and ureg_rsp_if.
//
// Usage:
//   req_i carries one transaction per item: a bus read, a bus write, a
//   character from the line, or a transmit slot in which the line takes one
//   character. rsp_o returns exactly one transaction per request, in order,
//   with the read value, interrupt level, any transmitted character and the
//   receiver/transmitter run flags as they stand after the item.
//   Path: a request accepted into the input stage is processed by one level
//   of logic, and its response is registered in the response register once
//   that register is free, so a stall on rsp_o can hold it in between.
//   Throughput: one transaction per cycle while rsp_o is not held off, set by
//   the single read-modify-write of the state registers between the stages.
//   Stall: when rsp_o is held off, one response waits in the output register
//   and one more request is still taken into the input stage; only then does
//   req_i.ready drop. No transaction is dropped or repeated.
//   Reset: rst_ni clears both stages and puts all registers at their reset
//   values (status with transmit ready and transmit empty set, clock ratio
//   at its default); req_i.ready is high as soon as reset is released.
module usart_register_block_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  ureg_req_if.sink      req_i,
  ureg_rsp_if.source    rsp_o
);
  import ureg_pkg::*;

  // Input stage
  logic                 in_vld_q;
  logic [CmdW-1:0]      cmd_q;
  logic [IdxW-1:0]      idx_q;
  logic [DataW-1:0]     wdata_q;
  logic [CharW-1:0]     rxc_q;

  // Response register
  logic                 out_vld_q;
  logic [DataW-1:0]     rdata_q;
  logic                 irq_q;
  logic                 txv_q;
  logic [CharW-1:0]     txc_q;
  logic                 rxl_q;
  logic                 txb_q;

  // Architectural state
  logic [CtrlW-1:0]     cw_q,    cw_d;
  logic [ModeW-1:0]     mode_q,  mode_d;
  logic [CtrlW-1:0]     imask_q, imask_d;
  logic [StatW-1:0]     st_q,    st_d;
  logic [CharW-1:0]     rhr_q,   rhr_d;
  logic [CharW-1:0]     thr_q,   thr_d;
  logic [CharW-1:0]     tsr_q,   tsr_d;
  logic [RtoW-1:0]      rto_q,   rto_d;
  logic [DataW-1:0]     guard_q, guard_d;
  logic [BrW-1:0]       ratio_q, ratio_d;
  logic [IrdaW-1:0]     irda_q,  irda_d;
  logic                 rx_run_q, rx_run_d;
  logic                 tx_run_q, tx_run_d;

  logic                 advance;
  logic                 step;
  logic [DataW-1:0]     rdata_d;
  logic                 txv_d;
  logic [CharW-1:0]     txc_d;
  logic                 irq_d;

  // Output register frees when empty or taken; input stage frees when it
  // moves on.
  assign advance      = !out_vld_q || rsp_o.ready;
  assign step         = in_vld_q && advance;
  assign req_i.ready  = !in_vld_q || advance;

  // Next-state and response logic for the item in the input stage
  always_comb begin
    logic [CtrlW-1:0] ena;
    logic [CtrlW-1:0] disa;
    logic [CtrlW-1:0] cw_new;
    logic [CtrlW-1:0] chg;
    logic [CtrlW-1:0] wlow;

    cw_d     = cw_q;
    mode_d   = mode_q;
    imask_d  = imask_q;
    st_d     = st_q;
    rhr_d    = rhr_q;
    thr_d    = thr_q;
    tsr_d    = tsr_q;
    rto_d    = rto_q;
    guard_d  = guard_q;
    ratio_d  = ratio_q;
    irda_d   = irda_q;
    rx_run_d = rx_run_q;
    tx_run_d = tx_run_q;
    rdata_d  = '0;
    txv_d    = 1'b0;
    txc_d    = '0;

    wlow   = wdata_q[CtrlW-1:0];
    ena    = wlow & CrEna;
    disa   = wlow & CrDisa;
    // Disable first, enable second, so enable wins; action bits just latch
    cw_new = (cw_q | disa) & ~(disa >> 1);
    cw_new = (cw_new | ena) & ~(ena << 1);
    cw_new = (cw_new & ~CrAction) | (wlow & CrAction);
    chg    = cw_new ^ cw_q;

    unique case (cmd_e'(cmd_q))
      CMD_READ: begin
        unique case (reg_e'(idx_q))
          REG_MR:   rdata_d = DataW'(mode_q);
          REG_IMR:  rdata_d = DataW'(imask_q);
          REG_CSR:  rdata_d = DataW'(st_q);
          REG_RHR: begin
            rdata_d = DataW'(rhr_q);
            if (st_q[StRxRdy]) begin
              // Consume the character, then re-arm the receiver if enabled
              st_d[StRxRdy] = 1'b0;
              if ((cw_q & CrRxDis) != '0) begin
                rx_run_d = 1'b0;
              end else if ((cw_q & CrRxEn) != '0) begin
                rx_run_d = 1'b1;
              end
            end
          end
          REG_RTOR: rdata_d = DataW'(rto_q);
          REG_TTGR: rdata_d = guard_q;
          REG_FIDI: rdata_d = DataW'(ratio_q);
          REG_IF:   rdata_d = DataW'(irda_q);
          default:  rdata_d = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (reg_e'(idx_q))
          REG_CR: begin
            cw_d = cw_new;
            if ((chg & (CrTxEn | CrTxDis)) != '0) begin
              if ((cw_new & CrTxDis) != '0) begin
                tx_run_d          = 1'b0;
                st_d[StTxEmpty]   = 1'b1;
                st_d[StTxRdy]     = 1'b1;
              end else if ((cw_new & CrTxEn) != '0) begin
                st_d[StTxEmpty]   = 1'b1;
                st_d[StTxRdy]     = 1'b1;
              end
            end
            if ((chg & (CrRxEn | CrRxDis)) != '0) begin
              if ((cw_new & CrRxDis) != '0) begin
                rx_run_d       = 1'b0;
                st_d[StRxRdy]  = 1'b0;
              end else if ((cw_new & CrRxEn) != '0) begin
                if (!st_q[StRxRdy]) begin
                  rx_run_d = 1'b1;
                end
              end
            end
          end
          REG_MR:   mode_d  = wdata_q[ModeW-1:0] & MrBits;
          REG_IER:  imask_d = imask_q | (wlow & ImBits);
          REG_IDR:  imask_d = imask_q & ~(wlow & ImBits);
          REG_THR: begin
            // Fill shift register first, then holding; drop when both full or TX off
            if ((cw_q & CrTxEn) != '0) begin
              if (st_q[StTxEmpty]) begin
                tsr_d           = wdata_q[CharW-1:0];
                st_d[StTxEmpty] = 1'b0;
                tx_run_d        = 1'b1;
              end else if (st_q[StTxRdy]) begin
                thr_d           = wdata_q[CharW-1:0];
                st_d[StTxRdy]   = 1'b0;
              end
            end
          end
          REG_RTOR: rto_d   = wdata_q[RtoW-1:0];
          REG_TTGR: guard_d = wdata_q;
          REG_FIDI: ratio_d = wdata_q[BrW-1:0];
          REG_IF:   irda_d  = wdata_q[IrdaW-1:0];
          default: begin
          end
        endcase
      end
      CMD_RX_CHAR: begin
        if (rx_run_q) begin
          rhr_d         = rxc_q;
          st_d[StRxRdy] = 1'b1;
          rx_run_d      = 1'b0;
        end
      end
      CMD_TX_SLOT: begin
        if (tx_run_q) begin
          if (!st_q[StTxEmpty]) begin
            txv_d = 1'b1;
            txc_d = tsr_q;
            if (!st_q[StTxRdy]) begin
              // Advance holding into shift register
              tsr_d         = thr_q;
              st_d[StTxRdy] = 1'b1;
            end else begin
              st_d[StTxEmpty] = 1'b1;
              tx_run_d        = 1'b0;
            end
          end else begin
            tx_run_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    irq_d = (st_d & imask_d[StatW-1:0]) != '0;
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      cmd_q   <= req_i.command;
      idx_q   <= req_i.reg_index;
      wdata_q <= req_i.write_data;
      rxc_q   <= req_i.rx_char;
    end
  end

  // Architectural state: update once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q     <= '0;
      mode_q   <= '0;
      imask_q  <= '0;
      st_q     <= StReset;
      rhr_q    <= '0;
      thr_q    <= '0;
      tsr_q    <= '0;
      rto_q    <= '0;
      guard_q  <= '0;
      ratio_q  <= BrReset;
      irda_q   <= '0;
      rx_run_q <= 1'b0;
      tx_run_q <= 1'b0;
    end else if (step) begin
      cw_q     <= cw_d;
      mode_q   <= mode_d;
      imask_q  <= imask_d;
      st_q     <= st_d;
      rhr_q    <= rhr_d;
      thr_q    <= thr_d;
      tsr_q    <= tsr_d;
      rto_q    <= rto_d;
      guard_q  <= guard_d;
      ratio_q  <= ratio_d;
      irda_q   <= irda_d;
      rx_run_q <= rx_run_d;
      tx_run_q <= tx_run_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      txv_q   <= txv_d;
      txc_q   <= txc_d;
      rxl_q   <= rx_run_d;
      txb_q   <= tx_run_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.read_data    = rdata_q;
  assign rsp_o.irq          = irq_q;
  assign rsp_o.tx_valid     = txv_q;
  assign rsp_o.tx_char      = txc_q;
  assign rsp_o.rx_listening = rxl_q;
  assign rsp_o.tx_busy      = txb_q;

  // Transmitter empty always implies holding register free
  a_empty_implies_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q[StTxEmpty] |-> st_q[StTxRdy])
    else $error("TXEMPTY set with TXRDY clear");

  // Receiver only listens while no character is pending
  a_rx_run_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_run_q |-> !st_q[StRxRdy])
    else $error("receiver running with RXRDY set");

  // Only RXRDY, TXRDY and TXEMPTY are ever set in status
  a_status_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q & ~StReset & ~(StatW'(1) << StRxRdy)) == '0)
    else $error("unexpected status bit set");

  // Input stage backs up only when it holds an item and the output is stalled
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_vld_q && out_vld_q && !rsp_o.ready))
    else $error("request ready low without a stall");

endmodule

// File: tb/sv/tb_usart_register_block_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for usart_register_block_top: a directed pass and
// weighted random traffic under several idle and stall patterns, each result
// checked against a cycle-free predictor. Uses ureg_pkg, ureg_req_if, ureg_rsp_if.
module tb_usart_register_block_top;
  import ureg_pkg::*;

  // One request transaction as driven on req_i.
  typedef struct packed {
    cmd_e                 command;
    logic [IdxW-1:0]      reg_index;
    logic [DataW-1:0]     write_data;
    logic [CharW-1:0]     rx_char;
  } usart_txn_t;

  // One response transaction as returned on rsp_o.
  typedef struct packed {
    logic [DataW-1:0]     read_data;
    logic                 irq;
    logic                 tx_valid;
    logic [CharW-1:0]     tx_char;
    logic                 rx_listening;
    logic                 tx_busy;
  } usart_result_t;

  logic clk_i;
  logic rst_ni;

  ureg_req_if req_if ();
  ureg_rsp_if rsp_if ();

  usart_register_block_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Register image tracked by the predictor.
  logic [CtrlW-1:0]  cr_bits;
  logic [ModeW-1:0]  mr_bits;
  logic [CtrlW-1:0]  imr_bits;
  logic [StatW-1:0]  csr_bits;
  logic [CharW-1:0]  rhr_char;
  logic [CharW-1:0]  thr_char;
  logic [CharW-1:0]  shift_char;
  logic [RtoW-1:0]   rtor_val;
  logic [DataW-1:0]  ttgr_val;
  logic [BrW-1:0]    fidi_val;
  logic [IrdaW-1:0]  if_val;
  logic              rx_armed;
  logic              tx_active;

  // Responses predicted for accepted requests, oldest first.
  usart_result_t pending_results[$];

  int unsigned fail_count = 0;
  int unsigned gap_pct    = 0;  // chance per cycle that the sender idles
  int unsigned stall_pct  = 0;  // chance per cycle that the receiver stalls
  int unsigned hold_left  = 0;  // remaining cycles of a forced receiver hold-off

  // Free-running clock, 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Re-evaluate the receiver after a control change or a holding read.
  function automatic void rearm_receiver();
    if ((cr_bits & CrRxDis) != '0) begin
      rx_armed           = 1'b0;
      csr_bits[StRxRdy]  = 1'b0;
    end else if ((cr_bits & CrRxEn) != '0) begin
      if (!csr_bits[StRxRdy]) rx_armed = 1'b1;
    end
  endfunction

  // Apply a control word write: disable half first, then enable, so the
  // enable wins when both bits of a pair are set; action bits just latch.
  function automatic void apply_cr_write(logic [DataW-1:0] v);
    logic [CtrlW-1:0] prev;
    logic [CtrlW-1:0] ena;
    logic [CtrlW-1:0] dis;
    logic [CtrlW-1:0] nxt;
    logic [CtrlW-1:0] chg;
    prev = cr_bits;
    ena  = v[CtrlW-1:0] & CrEna;
    dis  = v[CtrlW-1:0] & CrDisa;
    nxt  = (cr_bits | dis) & ~(dis >> 1);
    nxt  = (nxt | ena) & ~(ena << 1);
    nxt  = (nxt & ~CrAction) | (v[CtrlW-1:0] & CrAction);
    chg  = nxt ^ prev;
    cr_bits = nxt;
    // A change of the transmitter pair empties both buffers.
    if ((chg & (CrTxEn | CrTxDis)) != '0) begin
      if ((cr_bits & CrTxDis) != '0) begin
        tx_active            = 1'b0;
        csr_bits[StTxEmpty]  = 1'b1;
        csr_bits[StTxRdy]    = 1'b1;
      end else if ((cr_bits & CrTxEn) != '0) begin
        csr_bits[StTxEmpty]  = 1'b1;
        csr_bits[StTxRdy]    = 1'b1;
      end
    end
    if ((chg & (CrRxEn | CrRxDis)) != '0) rearm_receiver();
  endfunction

  // Load a character into the shift stage if empty, else into the holding
  // stage if free; drop it when both are full or the transmitter is off.
  function automatic void load_tx_buffer(logic [DataW-1:0] v);
    if ((cr_bits & CrTxEn) == '0) return;
    if (csr_bits[StTxEmpty]) begin
      shift_char           = v[CharW-1:0];
      csr_bits[StTxEmpty]  = 1'b0;
      tx_active            = 1'b1;
    end else if (csr_bits[StTxRdy]) begin
      thr_char             = v[CharW-1:0];
      csr_bits[StTxRdy]    = 1'b0;
    end
  endfunction

  function automatic logic [DataW-1:0] read_register(logic [IdxW-1:0] idx);
    logic [DataW-1:0] val;
    val = '0;
    case (idx)
      REG_MR:   val = 32'(mr_bits);
      REG_IMR:  val = 32'(imr_bits);
      REG_CSR:  val = 32'(csr_bits);
      REG_RHR: begin
        val = 32'(rhr_char);
        // Reading a full holding register frees it and may re-arm the receiver.
        if (csr_bits[StRxRdy]) begin
          csr_bits[StRxRdy] = 1'b0;
          rearm_receiver();
        end
      end
      REG_RTOR: val = 32'(rtor_val);
      REG_TTGR: val = ttgr_val;
      REG_FIDI: val = 32'(fidi_val);
      REG_IF:   val = 32'(if_val);
      default:  val = '0;
    endcase
    return val;
  endfunction

  function automatic void write_register(logic [IdxW-1:0] idx, logic [DataW-1:0] v);
    case (idx)
      REG_CR:   apply_cr_write(v);
      REG_MR:   mr_bits  = v[ModeW-1:0] & MrBits;
      REG_IER:  imr_bits = imr_bits | (v[CtrlW-1:0] & ImBits);
      REG_IDR:  imr_bits = imr_bits & ~(v[CtrlW-1:0] & ImBits);
      REG_THR:  load_tx_buffer(v);
      REG_RTOR: rtor_val = v[RtoW-1:0];
      REG_TTGR: ttgr_val = v;
      REG_FIDI: fidi_val = v[BrW-1:0];
      REG_IF:   if_val   = v[IrdaW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the register image by one request and return its response.
  function automatic usart_result_t predict_result(usart_txn_t t);
    usart_result_t r;
    r = '0;
    case (t.command)
      CMD_READ:  r.read_data = read_register(t.reg_index);
      CMD_WRITE: write_register(t.reg_index, t.write_data);
      CMD_RX_CHAR: begin
        if (rx_armed) begin
          rhr_char          = t.rx_char;
          csr_bits[StRxRdy] = 1'b1;
          rx_armed          = 1'b0;
        end
      end
      default: begin
        // Line slot: shift out one character, then refill from holding.
        if (tx_active) begin
          if (!csr_bits[StTxEmpty]) begin
            r.tx_valid = 1'b1;
            r.tx_char  = shift_char;
            if (!csr_bits[StTxRdy]) begin
              shift_char        = thr_char;
              csr_bits[StTxRdy] = 1'b1;
            end else begin
              csr_bits[StTxEmpty] = 1'b1;
              tx_active           = 1'b0;
            end
          end else begin
            tx_active = 1'b0;
          end
        end
      end
    endcase
    r.irq          = |(csr_bits & imr_bits[StatW-1:0]);
    r.rx_listening = rx_armed;
    r.tx_busy      = tx_active;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and monitor
  // ---------------------------------------------------------------------------

  // Drive one request; idle at random first, then hold valid until accepted.
  // Leave valid high on return so back-to-back transactions need no toggle.
  task automatic send_txn(input usart_txn_t t);
    @(negedge clk_i);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= t.command;
    req_if.reg_index  <= t.reg_index;
    req_if.write_data <= t.write_data;
    req_if.rx_char    <= t.rx_char;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_result(t));
  endtask

  task automatic send_fields(input cmd_e c, input logic [IdxW-1:0] idx,
                             input logic [DataW-1:0] wd, input logic [CharW-1:0] ch);
    usart_txn_t t;
    t.command    = c;
    t.reg_index  = idx;
    t.write_data = wd;
    t.rx_char    = ch;
    send_txn(t);
  endtask

  // Drop valid and hold until every predicted response has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Receiver back-pressure: a forced hold-off takes priority over random stalls.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    = hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(string name, logic [DataW-1:0] want,
                                      logic [DataW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk_i) begin
    usart_result_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected response: expected none, actual read_data %h tx %b/%h",
                 $time, rsp_if.read_data, rsp_if.tx_valid, rsp_if.tx_char);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data",    want.read_data,          rsp_if.read_data);
        check_field("irq",          32'(want.irq),           32'(rsp_if.irq));
        check_field("tx_valid",     32'(want.tx_valid),      32'(rsp_if.tx_valid));
        check_field("tx_char",      32'(want.tx_char),       32'(rsp_if.tx_char));
        check_field("rx_listening", 32'(want.rx_listening),  32'(rsp_if.rx_listening));
        check_field("tx_busy",      32'(want.tx_busy),       32'(rsp_if.tx_busy));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Weighted traffic: mostly well-formed enable/transmit/receive/read flows,
  // the rest arbitrary writes, reads and fully random requests.
  function automatic usart_txn_t random_txn();
    usart_txn_t  t;
    int unsigned pick;
    t.command    = CMD_WRITE;
    t.reg_index  = IdxW'($urandom_range(31));
    t.write_data = $urandom();
    t.rx_char    = CharW'($urandom_range(511));
    pick = $urandom_range(99);
    if (pick < 8) begin
      t.reg_index = REG_CR;
      case ($urandom_range(9))
        0: ;  // keep the fully random control word
        1, 2: t.write_data = $urandom() & 32'(CrRxDis | CrTxDis);
        default: t.write_data = 32'(CrRxEn | CrTxEn) | ($urandom() & 32'(CrAction));
      endcase
    end else if (pick < 28) begin
      t.reg_index = REG_THR;
    end else if (pick < 50) begin
      t.command = CMD_TX_SLOT;
    end else if (pick < 65) begin
      t.command = CMD_RX_CHAR;
    end else if (pick < 80) begin
      t.command = CMD_READ;
      case ($urandom_range(3))
        0, 1: t.reg_index = REG_RHR;
        2:    t.reg_index = REG_CSR;
        default: ;
      endcase
    end else if (pick < 92) begin
      case ($urandom_range(2))
        0: t.reg_index = REG_IER;
        1: t.reg_index = REG_IDR;
        default: ;
      endcase
    end else begin
      t.command = cmd_e'($urandom_range(3));
    end
    return t;
  endfunction

  // Reset image: unreadable/unmapped reads, an idle line slot, a character
  // while not listening and a holding write while the transmitter is off.
  task automatic test_reset_state();
    send_fields(CMD_READ,    REG_CSR,  '0, '0);
    send_fields(CMD_READ,    REG_FIDI, '0, '0);
    send_fields(CMD_READ,    REG_CR,   '1, '1);
    send_fields(CMD_READ,    5'd31,    '0, '0);
    send_fields(CMD_TX_SLOT, REG_THR,  '0, '0);
    send_fields(CMD_RX_CHAR, REG_RHR,  '0, 9'h1ff);
    send_fields(CMD_WRITE,   REG_THR,  '1, '0);
  endtask

  // All-ones writes to writable, read-only and unmapped registers.
  task automatic test_register_limits();
    send_fields(CMD_WRITE, REG_MR,  '1, '0);
    send_fields(CMD_WRITE, REG_IER, '1, '0);
    send_fields(CMD_WRITE, REG_CSR, '1, '0);
    send_fields(CMD_WRITE, 5'd31,   '1, '0);
    send_fields(CMD_READ,  REG_MR,  '0, '0);
    send_fields(CMD_READ,  REG_IMR, '0, '0);
  endtask

  // Every enable and disable bit at once: enables must win.
  task automatic test_control_pairs();
    send_fields(CMD_WRITE, REG_CR,  '1, '0);
    send_fields(CMD_READ,  REG_CSR, '0, '0);
  endtask

  // Fill shift and holding stages, overflow once, then drain to idle.
  task automatic test_tx_buffering();
    send_fields(CMD_WRITE,   REG_THR, 32'h0000_01ff, '0);
    send_fields(CMD_WRITE,   REG_THR, 32'hffff_fe00, '0);
    send_fields(CMD_WRITE,   REG_THR, 32'h0000_00aa, '0);
    repeat (3) send_fields(CMD_TX_SLOT, '0, '0, '0);
  endtask

  // Catch one character, drop the next, read the holding register twice.
  task automatic test_rx_holding();
    send_fields(CMD_RX_CHAR, '0,      '0, 9'h155);
    send_fields(CMD_RX_CHAR, '0,      '0, 9'h0aa);
    send_fields(CMD_READ,    REG_RHR, '0, '0);
    send_fields(CMD_READ,    REG_RHR, '0, '0);
    send_fields(CMD_WRITE,   REG_IDR, '1, '0);
    send_fields(CMD_WRITE,   REG_CR,  32'(CrRxDis | CrTxDis), '0);
  endtask

  task automatic test_random_traffic(input int unsigned gaps, input int unsigned stalls,
                                     input int unsigned count);
    gap_pct   = gaps;
    stall_pct = stalls;
    repeat (count) send_txn(random_txn());
    wait_drained();
  endtask

  // Hold the receiver off long enough for both stages to fill and req_i to
  // stall, while the sender keeps offering transactions.
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 64;
    repeat (20) send_txn(random_txn());
    wait_drained();
  endtask

  // Pause the sender mid-stream until every response is back, then resume.
  task automatic test_pause_until_drained();
    gap_pct   = 0;
    stall_pct = 19;
    repeat (12) send_txn(random_txn());
    wait_drained();
    repeat (12) send_txn(random_txn());
    wait_drained();
  endtask

  // Predictor reset values mirror the block's reset state.
  initial begin
    cr_bits    = '0;
    mr_bits    = '0;
    imr_bits   = '0;
    csr_bits   = StReset;
    rhr_char   = '0;
    thr_char   = '0;
    shift_char = '0;
    rtor_val   = '0;
    ttgr_val   = '0;
    fidi_val   = BrReset;
    if_val     = '0;
    rx_armed   = 1'b0;
    tx_active  = 1'b0;
  end

  // Main sequence: reset once, directed tests, then random phases.
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_READ;
    req_if.reg_index  = '0;
    req_if.write_data = '0;
    req_if.rx_char    = '0;
    rsp_if.ready      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_limits();
    test_control_pairs();
    test_tx_buffering();
    test_rx_holding();
    wait_drained();

    test_random_traffic(0,  0,  110);
    test_random_traffic(45, 0,  110);
    test_random_traffic(0,  45, 110);
    test_random_traffic(19, 19, 110);
    test_backpressure();
    test_pause_until_drained();

    // Let any stray response surface before the verdict.
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
